>>> rtl/core/svf_pkg.sv
package svf_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int COEF_BITS_DEFAULT   = 24;

   localparam int STATE_BITS = 32;
   localparam int STATE_FRAC = 24;
   localparam int COEF_INT   = 4;

   // Difference term, scaled products and their sums with a state.
   localparam int DIFF_BITS = STATE_BITS + 2;
   localparam int PROD_BITS = DIFF_BITS + COEF_INT;
   localparam int SUM_BITS  = PROD_BITS + 1;

   localparam int MODE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_LOW_PASS  = 2'd0,
      MODE_HIGH_PASS = 2'd1,
      MODE_BAND_PASS = 2'd2
   } filter_mode_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FILTER_MODE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_FIRST_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_SECOND_GAIN = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_DIRECT_GAIN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_BAND_GAIN   = 3'd4;

   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [SUM_BITS-1:0] value
   );
      logic [SUM_BITS-STATE_BITS:0] top;
      begin
         top = value[SUM_BITS-1:STATE_BITS-1];
         if (&top || ~|top) begin
            sat_state = value[STATE_BITS-1:0];
         end else if (value[SUM_BITS-1]) begin
            sat_state = {1'b1, {(STATE_BITS-1){1'b0}}};
         end else begin
            sat_state = {1'b0, {(STATE_BITS-1){1'b1}}};
         end
      end
   endfunction

endpackage

>>> rtl/core/state_variable_filter_unit.sv
// Second-order state variable filter, one audio sample in and one out.
// Samples enter on the req channel and leave on the rsp channel, both
// valid/ready; a transfer happens when valid and ready are both high.
// The csr port writes the mode and the four Q4 gains; the user must write
// it only while no sample is in flight; the block itself does not enforce this.
// The sample is registered in the input register; then the difference,
// the four gain products, the state updates and the output are formed
// combinationally into the output register while the two integrator
// states update in the same cycle.
// Throughput is one sample per cycle while the receiver does not stall;
// the state update loop through the gain multipliers is combinational.
// When the receiver stalls, the output register holds its sample, the
// input register fills, and req_ready drops until rsp_ready returns.
// Reset clears both states, all configuration registers and both valid
// flags; req_ready is high as soon as reset is released.
module state_variable_filter_unit #(
   parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COEF_BITS   = svf_pkg::COEF_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   input  logic                                  csr_we,
   input  logic [svf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [COEF_BITS-1:0]                  csr_wdata
);

   logic [svf_pkg::MODE_BITS-1:0]          mode_ff;
   logic signed [COEF_BITS-1:0]            coef_first_ff;
   logic signed [COEF_BITS-1:0]            coef_second_ff;
   logic signed [COEF_BITS-1:0]            coef_direct_ff;
   logic signed [COEF_BITS-1:0]            coef_band_ff;
   logic signed [svf_pkg::STATE_BITS-1:0]  first_state_ff;
   logic signed [svf_pkg::STATE_BITS-1:0]  second_state_ff;
   logic signed [svf_pkg::STATE_BITS-1:0]  first_state_in;
   logic signed [svf_pkg::STATE_BITS-1:0]  second_state_in;
   logic                                   in_valid_ff;
   logic signed [SAMPLE_BITS-1:0]          in_sample_ff;
   logic                                   out_valid_ff;
   logic signed [SAMPLE_BITS-1:0]          out_sample_ff;
   logic signed [SAMPLE_BITS-1:0]          out_sample_in;
   logic                                   advance;
   logic                                   fire;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = advance && in_valid_ff;
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= '0;
         coef_first_ff  <= '0;
         coef_second_ff <= '0;
         coef_direct_ff <= '0;
         coef_band_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            svf_pkg::REG_FILTER_MODE:      mode_ff        <= csr_wdata[svf_pkg::MODE_BITS-1:0];
            svf_pkg::REG_COEF_FIRST_GAIN:  coef_first_ff  <= csr_wdata;
            svf_pkg::REG_COEF_SECOND_GAIN: coef_second_ff <= csr_wdata;
            svf_pkg::REG_COEF_DIRECT_GAIN: coef_direct_ff <= csr_wdata;
            svf_pkg::REG_COEF_BAND_GAIN:   coef_band_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         first_state_ff  <= '0;
         second_state_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            first_state_ff  <= first_state_in;
            second_state_ff <= second_state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_sample_in;
      end
      if (fire) begin
         out_sample_ff <= out_sample_in;
      end
   end

   svf_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_datapath (
      .sample           (in_sample_ff),
      .mode             (mode_ff),
      .coef_first_gain  (coef_first_ff),
      .coef_second_gain (coef_second_ff),
      .coef_direct_gain (coef_direct_ff),
      .coef_band_gain   (coef_band_ff),
      .first_state      (first_state_ff),
      .second_state     (second_state_ff),
      .first_state_in   (first_state_in),
      .second_state_in  (second_state_in),
      .out_sample_in    (out_sample_in)
   );

endmodule

>>> rtl/core/svf_datapath.sv
module svf_datapath #(
   parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COEF_BITS   = svf_pkg::COEF_BITS_DEFAULT
) (
   input  logic signed [SAMPLE_BITS-1:0]          sample,
   input  logic [svf_pkg::MODE_BITS-1:0]          mode,
   input  logic signed [COEF_BITS-1:0]            coef_first_gain,
   input  logic signed [COEF_BITS-1:0]            coef_second_gain,
   input  logic signed [COEF_BITS-1:0]            coef_direct_gain,
   input  logic signed [COEF_BITS-1:0]            coef_band_gain,
   input  logic signed [svf_pkg::STATE_BITS-1:0]  first_state,
   input  logic signed [svf_pkg::STATE_BITS-1:0]  second_state,
   output logic signed [svf_pkg::STATE_BITS-1:0]  first_state_in,
   output logic signed [svf_pkg::STATE_BITS-1:0]  second_state_in,
   output logic signed [SAMPLE_BITS-1:0]          out_sample_in
);

   localparam int SF    = SAMPLE_BITS - 1;
   localparam int SFRAC = svf_pkg::STATE_FRAC;
   localparam int CF    = COEF_BITS - svf_pkg::COEF_INT;
   localparam int XW    = svf_pkg::DIFF_BITS;
   localparam int MW    = svf_pkg::PROD_BITS;
   localparam int AW    = svf_pkg::SUM_BITS;
   localparam int PW    = COEF_BITS + XW;
   localparam int OW    = (SF >= SFRAC) ? AW + SF - SFRAC : AW - (SFRAC - SF);

   logic signed [SFRAC:0]    sample_q;
   logic signed [XW-1:0]     diff;
   logic signed [XW-1:0]     first_ext;
   logic signed [PW-1:0]     prod_first;
   logic signed [PW-1:0]     prod_second;
   logic signed [PW-1:0]     prod_direct;
   logic signed [PW-1:0]     prod_band;
   logic signed [MW-1:0]     step_first;
   logic signed [MW-1:0]     step_second;
   logic signed [MW-1:0]     direct;
   logic signed [MW-1:0]     band;
   logic signed [AW-1:0]     sum_first;
   logic signed [AW-1:0]     sum_second;
   logic signed [AW-1:0]     acc;
   logic signed [OW-1:0]     out_wide;
   logic [OW-SAMPLE_BITS:0]  out_top;

   generate
      if (SF < SFRAC) begin : g_sample_up
         assign sample_q = {sample, {(SFRAC-SF){1'b0}}};
      end else begin : g_sample_down
         assign sample_q = sample[SAMPLE_BITS-1 -: SFRAC+1];
      end
   endgenerate

   assign first_ext = XW'(first_state);
   assign diff      = XW'(sample_q) - first_ext - XW'(second_state);

   assign prod_first  = coef_first_gain * diff;
   assign prod_second = coef_second_gain * first_ext;
   assign prod_direct = coef_direct_gain * diff;
   assign prod_band   = coef_band_gain * first_ext;

   assign step_first  = prod_first[PW-1:CF];
   assign step_second = prod_second[PW-1:CF];
   assign direct      = prod_direct[PW-1:CF];
   assign band        = prod_band[PW-1:CF];

   assign sum_first  = AW'(first_state) + AW'(step_first);
   assign sum_second = AW'(second_state) + AW'(step_second);

   assign first_state_in  = svf_pkg::sat_state(sum_first);
   assign second_state_in = svf_pkg::sat_state(sum_second);

   always_comb begin
      case (mode)
         svf_pkg::MODE_LOW_PASS:  acc = AW'(direct) + AW'(second_state_in);
         svf_pkg::MODE_HIGH_PASS: acc = AW'(direct);
         svf_pkg::MODE_BAND_PASS: acc = AW'(direct) + AW'(band);
         default:                 acc = '0;
      endcase
   end

   generate
      if (SF > SFRAC) begin : g_out_up
         assign out_wide = {acc, {(SF-SFRAC){1'b0}}};
      end else begin : g_out_down
         assign out_wide = acc[AW-1:SFRAC-SF];
      end
   endgenerate

   assign out_top = out_wide[OW-1:SAMPLE_BITS-1];

   always_comb begin
      if (&out_top || ~|out_top) begin
         out_sample_in = out_wide[SAMPLE_BITS-1:0];
      end else if (out_wide[OW-1]) begin
         out_sample_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         out_sample_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

endmodule
